// ===== hdl/quoted_printable_decoder_defines.svh =====
// assertion macros used by the decoder back end (qpd_back)
`ifndef QUOTED_PRINTABLE_DECODER_DEFINES_SVH
`define QUOTED_PRINTABLE_DECODER_DEFINES_SVH

// property checked on every rising clock edge outside reset
`define QPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never hold outside reset
`define QPD_ASSERT_NEVER(lbl, expr, msg) \
  `QPD_ASSERT(lbl, !(expr), msg)

`endif

// ===== hdl/qpd_pkg.sv =====
`default_nettype none

package qpd_pkg;

  localparam logic [7:0] ChEq     = 8'h3D;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChNulSub = 8'h3F;

  localparam int unsigned WinBytes = 3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_stream;
  } qpd_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       stream_done;
  } qpd_out_t;

  typedef logic [WinBytes-1:0][7:0] qpd_bytes_t;

  typedef struct packed {
    qpd_bytes_t win;
    logic [1:0] wn;
    qpd_bytes_t ob;
    logic [1:0] on;
  } qpd_work_t;

  // decoded bytes of one input transfer
  typedef struct packed {
    qpd_bytes_t bytes;
    logic [1:0] cnt;
    logic       eos;
  } qpd_entry_t;

  // msb flags a hex digit
  function automatic logic [4:0] hex_val(logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic logic [7:0] plain(logic [7:0] c);
    return (c == ChNul) ? ChNulSub : c;
  endfunction

  function automatic qpd_work_t emit(qpd_work_t w, logic [7:0] b);
    if (w.on != 2'd3) begin
      w.ob[w.on] = b;
      w.on       = w.on + 2'd1;
    end
    return w;
  endfunction

  function automatic qpd_work_t pop1(qpd_work_t w);
    w.win = {8'h00, w.win[WinBytes-1:1]};
    w.wn  = w.wn - 2'd1;
    return w;
  endfunction

  function automatic qpd_work_t pop3(qpd_work_t w);
    w.win = '0;
    w.wn  = 2'd0;
    return w;
  endfunction

  // settle leading bytes that no longer depend on the line end
  function automatic qpd_work_t drain(qpd_work_t w);
    logic       stop;
    logic [4:0] a;
    logic [4:0] b;
    stop = 1'b0;
    for (int i = 0; i < WinBytes; i++) begin
      a = hex_val(w.win[1]);
      b = hex_val(w.win[2]);
      if (!stop && w.wn != 2'd0) begin
        if (w.win[0] == ChCr) begin
          if (w.wn < 2'd2) begin
            stop = 1'b1;
          end else begin
            w = emit(w, ChCr);
            w = pop1(w);
          end
        end else if (w.win[0] == ChEq) begin
          if (w.wn < 2'd2) begin
            stop = 1'b1;
          end else if (a[4]) begin
            if (w.wn < 2'd3) begin
              stop = 1'b1;
            end else if (b[4]) begin
              w = emit(w, {a[3:0], b[3:0]});
              w = pop3(w);
            end else begin
              w = emit(w, ChEq);
              w = pop1(w);
            end
          end else if (w.win[1] == ChCr && w.wn < 2'd3) begin
            stop = 1'b1;
          end else begin
            w = emit(w, ChEq);
            w = pop1(w);
          end
        end else begin
          w = emit(w, plain(w.win[0]));
          w = pop1(w);
        end
      end
    end
    return w;
  endfunction

  // close the line: strip cr, detect soft break, flush the tail, add lf if asked and no soft break
  function automatic qpd_work_t finish(qpd_work_t w, logic with_lf);
    logic       soft_brk;
    logic [1:0] n;
    logic [4:0] a;
    logic [4:0] b;
    soft_brk = 1'b0;
    n        = w.wn;
    if (n != 2'd0 && w.win[n - 2'd1] == ChCr) begin
      n = n - 2'd1;
    end
    if (n != 2'd0 && w.win[n - 2'd1] == ChEq) begin
      n        = n - 2'd1;
      soft_brk = 1'b1;
    end
    w.wn = n;
    for (int i = 0; i < WinBytes; i++) begin
      a = hex_val(w.win[1]);
      b = hex_val(w.win[2]);
      if (w.wn != 2'd0) begin
        if (w.win[0] == ChEq) begin
          if (w.wn == 2'd3 && a[4] && b[4]) begin
            w = emit(w, {a[3:0], b[3:0]});
            w = pop3(w);
          end else begin
            w = emit(w, ChEq);
            w = pop1(w);
          end
        end else begin
          w = emit(w, plain(w.win[0]));
          w = pop1(w);
        end
      end
    end
    if (with_lf && !soft_brk) begin
      w = emit(w, ChLf);
    end
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/qpd_front.sv =====
`default_nettype none

module qpd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  qpd_pkg::qpd_in_t   in_data_i,
  input  logic               q_full_i,
  output logic               push_o,
  output qpd_pkg::qpd_entry_t entry_o
);
  import qpd_pkg::*;

  logic [1:0][7:0] held_q, held_d;
  logic [1:0]      held_n_q, held_n_d;
  logic            accept;
  qpd_work_t       w;

  always_comb begin
    w.win = {8'h00, held_q};
    w.wn  = held_n_q;
    w.ob  = '0;
    w.on  = 2'd0;
    if (in_data_i.in_byte == ChLf) begin
      w = finish(w, 1'b1);
    end else begin
      w.win[w.wn] = in_data_i.in_byte;
      w.wn        = w.wn + 2'd1;
      w           = drain(w);
      if (in_data_i.end_of_stream) begin
        w = finish(w, 1'b0);
      end
    end
    held_d   = w.win[1:0];
    held_n_d = in_data_i.end_of_stream ? 2'd0 : w.wn;
  end

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;
  assign push_o     = accept && (w.on != 2'd0 || in_data_i.end_of_stream);
  assign entry_o    = '{bytes: w.ob, cnt: w.on, eos: in_data_i.end_of_stream};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_n_q <= 2'd0;
    end else if (accept) begin
      held_n_q <= held_n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      held_q <= held_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/qpd_fifo.sv =====
`default_nettype none

module qpd_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  qpd_pkg::qpd_entry_t entry_i,
  output logic                full_o,
  input  logic                pop_i,
  output qpd_pkg::qpd_entry_t head_o,
  output logic                empty_o
);
  import qpd_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  qpd_entry_t      mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntFull);
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/qpd_back.sv =====
`default_nettype none

`include "quoted_printable_decoder_defines.svh"

module qpd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  qpd_pkg::qpd_entry_t head_i,
  input  logic                empty_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output qpd_pkg::qpd_out_t   out_data_o
);
  import qpd_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  qpd_out_t   out_q, cur;
  logic       load;
  logic       last;

  always_comb begin
    if (head_i.cnt == 2'd0) begin
      last = 1'b1;
      cur  = '{out_byte: 8'h00, byte_valid: 1'b0, run_last: 1'b1, stream_done: 1'b1};
    end else begin
      last = (idx_q == head_i.cnt - 2'd1);
      cur  = '{out_byte: head_i.bytes[idx_q], byte_valid: 1'b1, run_last: last,
               stream_done: last && head_i.eos};
    end
  end

  assign load  = !empty_i && (!out_valid_q || !out_stall_i);
  assign pop_o = load && last;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      idx_d       = last ? 2'd0 : idx_q + 2'd1;
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= cur;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // bare end marker only closes a stream
  `QPD_ASSERT(a_bare_marker, out_valid_o && !out_data_o.byte_valid |-> out_data_o.run_last && out_data_o.stream_done, "bare marker not final")
  `QPD_ASSERT_NEVER(a_done_not_last, out_valid_o && out_data_o.stream_done && !out_data_o.run_last, "stream end before last result of transfer")
  `QPD_ASSERT(a_idx_in_range, !empty_i && head_i.cnt != 2'd0 |-> idx_q < head_i.cnt, "result index past entry")

endmodule

`default_nettype wire

// ===== hdl/quoted_printable_decoder.sv =====
// Quoted-printable decoder. One encoded byte is taken per cycle on the input
// channel unless it is stalled; each byte gives zero to three decoded result
// items (a line end, a stream end or a byte after a held '=' and CR can give
// three), and the output channel delivers one result per cycle unless it is
// stalled. The front end keeps up to two undecided bytes of the current line
// and decodes each byte in the cycle it arrives; a queue of QueueDepth entries
// sits between it and the output serialiser, so the input only stalls when the
// queue fills, i.e. when results build up faster than one per cycle or the
// output is stalled. The first result of a byte is written into the queue and
// then into the serialiser's output register. A stream-end byte with no decoded
// data gives a single bare end marker. There is no clearing pass after reset.
`default_nettype none

module quoted_printable_decoder #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  qpd_pkg::qpd_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output qpd_pkg::qpd_out_t out_data_o
);
  import qpd_pkg::*;

  logic       push;
  logic       q_full;
  logic       q_empty;
  logic       pop;
  qpd_entry_t entry;
  qpd_entry_t head;

  qpd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .entry_o    (entry)
  );

  qpd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (q_full),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (q_empty)
  );

  qpd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== tb/sv/quoted_printable_decoder_checker.sv =====
`timescale 1ns / 100ps

module quoted_printable_decoder_checker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  qpd_pkg::qpd_in_t  in_data_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  qpd_pkg::qpd_out_t out_data_i,
  output int               fail_count_o,
  output int               pending_o
);
  import qpd_pkg::*;

  logic [7:0] line_held [4];
  int         line_len = 0;
  logic [7:0] step_bytes [$];
  qpd_out_t   decoded_q [$];
  qpd_out_t   want;
  int         shown = 0;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic int digit_of(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) begin
      return int'(c) - 'h30;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      return int'(c) - 'h41 + 10;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      return int'(c) - 'h61 + 10;
    end
    return -1;
  endfunction

  function automatic void put_plain(logic [7:0] c);
    step_bytes.push_back((c == ChNul) ? ChNulSub : c);
  endfunction

  function automatic void drop(int n);
    for (int i = 0; i < 4; i++) begin
      line_held[i] = (i + n < 4) ? line_held[i + n] : 8'h00;
    end
    line_len -= n;
  endfunction

  function automatic void close_line(logic add_lf);
    int   n;
    logic soft_brk;
    int   hi;
    int   lo;
    n        = line_len;
    soft_brk = 1'b0;
    if (n > 0 && line_held[n - 1] == ChCr) begin
      n--;
    end
    if (n > 0 && line_held[n - 1] == ChEq) begin
      n--;
      soft_brk = 1'b1;
    end
    line_len = n;
    while (line_len > 0) begin
      hi = digit_of(line_held[1]);
      lo = digit_of(line_held[2]);
      if (line_held[0] == ChEq && line_len >= 3 && hi >= 0 && lo >= 0) begin
        step_bytes.push_back(8'(hi * 16 + lo));
        drop(3);
      end else if (line_held[0] == ChEq) begin
        step_bytes.push_back(ChEq);
        drop(1);
      end else begin
        put_plain(line_held[0]);
        drop(1);
      end
    end
    if (add_lf && !soft_brk) begin
      step_bytes.push_back(ChLf);
    end
  endfunction

  // decode one transfer and queue the results it gives
  function automatic void decode_transfer(qpd_in_t t);
    qpd_out_t r;
    logic     stop;
    int       hi;
    int       lo;
    step_bytes.delete();
    if (t.in_byte == ChLf) begin
      close_line(1'b1);
    end else begin
      if (line_len < 4) begin
        line_held[line_len] = t.in_byte;
        line_len++;
      end
      // settle leading bytes that no longer hang on the line end
      stop = 1'b0;
      while (!stop && line_len > 0) begin
        hi = digit_of(line_held[1]);
        lo = digit_of(line_held[2]);
        if (line_held[0] == ChCr) begin
          if (line_len < 2) begin
            stop = 1'b1;
          end else begin
            put_plain(ChCr);
            drop(1);
          end
        end else if (line_held[0] == ChEq) begin
          if (line_len < 2) begin
            stop = 1'b1;
          end else if (hi >= 0) begin
            if (line_len < 3) begin
              stop = 1'b1;
            end else if (lo >= 0) begin
              step_bytes.push_back(8'(hi * 16 + lo));
              drop(3);
            end else begin
              step_bytes.push_back(ChEq);
              drop(1);
            end
          end else if (line_held[1] == ChCr && line_len < 3) begin
            stop = 1'b1;
          end else begin
            step_bytes.push_back(ChEq);
            drop(1);
          end
        end else begin
          put_plain(line_held[0]);
          drop(1);
        end
      end
      if (t.end_of_stream) begin
        close_line(1'b0);
      end
    end
    if (t.end_of_stream) begin
      line_len = 0;
    end
    if (step_bytes.size() == 0 && t.end_of_stream) begin
      r = '{out_byte: 8'h00, byte_valid: 1'b0, run_last: 1'b1, stream_done: 1'b1};
      decoded_q.push_back(r);
    end
    for (int k = 0; k < step_bytes.size(); k++) begin
      r.out_byte    = step_bytes[k];
      r.byte_valid  = 1'b1;
      r.run_last    = (k == step_bytes.size() - 1);
      r.stream_done = r.run_last && t.end_of_stream;
      decoded_q.push_back(r);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_len = 0;
      decoded_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        decode_transfer(in_data_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (decoded_q.size() == 0) begin
          fail_count_o++;
          if (shown < 10) begin
            $display("%0t: unexpected result: byte %02h valid %b last %b done %b", $time,
                     out_data_i.out_byte, out_data_i.byte_valid, out_data_i.run_last,
                     out_data_i.stream_done);
            shown++;
          end
        end else begin
          want = decoded_q.pop_front();
          if (out_data_i.out_byte !== want.out_byte ||
              out_data_i.byte_valid !== want.byte_valid ||
              out_data_i.run_last !== want.run_last ||
              out_data_i.stream_done !== want.stream_done) begin
            fail_count_o++;
            if (shown < 10) begin
              $display({"%0t: mismatch: expected byte %02h valid %b last %b done %b, ",
                        "got byte %02h valid %b last %b done %b"},
                       $time, want.out_byte, want.byte_valid, want.run_last, want.stream_done,
                       out_data_i.out_byte, out_data_i.byte_valid, out_data_i.run_last,
                       out_data_i.stream_done);
              shown++;
            end
          end
        end
      end
    end
    pending_o = decoded_q.size();
  end

endmodule

// ===== tb/sv/quoted_printable_decoder_tb.sv =====
`timescale 1ns / 100ps

module quoted_printable_decoder_tb;
  import qpd_pkg::*;

  localparam int Items       = 470;
  localparam int QuietTail   = 60;
  localparam int HoldAt      = 200;
  localparam int HoldCycles  = 150;
  localparam int StuckLimit  = 1000;
  localparam int DrainCycles = 20;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  qpd_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  qpd_out_t out_data;
  logic     in_took;
  logic     hold_req;
  logic     hold_done;
  logic     quiet;
  int       sent = 0;
  int       stuck_cycles = 0;
  int       fail_count;
  int       pending;

  quoted_printable_decoder uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  quoted_printable_decoder_checker decode_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && !in_stall;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles == StuckLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: random stall bursts plus one long hold-off
  initial begin
    out_stall = 1'b0;
    hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(negedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [7:0] hex_char();
    string digits = "0123456789ABCDEFabcdef";
    return digits[$urandom_range(0, 21)];
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic eos);
    if (!quiet && !(sent >= HoldAt && sent < HoldAt + 80) && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{in_byte: b, end_of_stream: eos};
    do @(negedge clk); while (!in_took);
    sent++;
    if (sent == HoldAt) begin
      hold_req <= 1'b1;
    end
    if (sent == Items - QuietTail) begin
      quiet <= 1'b1;
    end
  endtask

  task automatic send_text(input string s, input logic eos_last);
    for (int i = 0; i < s.len(); i++) begin
      push_byte(s[i], eos_last && (i == s.len() - 1));
    end
  endtask

  initial begin
    in_valid = 1'b0;
    in_data  = '0;
    hold_req = 1'b0;
    quiet    = 1'b0;
    rst_n    = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // escapes, nul and top byte, bad escape, inner cr, soft break, cut-off escape
    send_text("=41=3d=00", 1'b0);
    push_byte(ChNul, 1'b0);
    push_byte(8'hFF, 1'b0);
    send_text("=Ga\015b=\015\n=4\n", 1'b0);
    // stream end with nothing decoded, then stream end on a line feed
    push_byte(ChEq, 1'b1);
    send_text("z", 1'b0);
    push_byte(ChLf, 1'b1);

    while (sent < Items) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6: begin
          push_byte(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
        end
        7, 8, 9: begin
          push_byte(ChEq, 1'b0);
          push_byte(hex_char(), 1'b0);
          push_byte(hex_char(), 1'b0);
        end
        10: begin
          push_byte(ChEq, 1'b0);
          if ($urandom_range(0, 1) == 1) begin
            push_byte(ChCr, 1'b0);
          end
          push_byte(ChLf, 1'b0);
        end
        11, 12: begin
          if ($urandom_range(0, 1) == 1) begin
            push_byte(ChCr, 1'b0);
          end
          push_byte(ChLf, 1'b0);
        end
        13: begin
          push_byte(ChEq, 1'b0);
          push_byte(8'($urandom_range(0, 255)), 1'b0);
          if ($urandom_range(0, 1) == 1) begin
            push_byte(hex_char(), 1'b0);
          end
        end
        14: begin
          push_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        15: begin
          push_byte(ChNul, 1'b0);
        end
        16: begin
          push_byte(ChCr, 1'b0);
          push_byte(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
        end
        17: begin
          push_byte(ChEq, 1'b0);
          push_byte(ChCr, 1'b0);
          push_byte(8'($urandom_range(8'h80, 8'hFF)), 1'b0);
        end
        18: begin
          push_byte(8'($urandom_range(8'h80, 8'hFF)), 1'b0);
        end
        default: begin
          case ($urandom_range(0, 3))
            0: push_byte(ChLf, 1'b1);
            1: push_byte(ChEq, 1'b1);
            2: push_byte(ChCr, 1'b1);
            default: push_byte(8'($urandom_range(0, 255)), 1'b1);
          endcase
        end
      endcase
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/qpd_pkg.sv
hdl/qpd_front.sv
hdl/qpd_fifo.sv
hdl/qpd_back.sv
hdl/quoted_printable_decoder.sv
tb/sv/quoted_printable_decoder_checker.sv
tb/sv/quoted_printable_decoder_tb.sv
